[rtl/cta_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the channel-tagged converter averager.
// No dependencies; cta_datapath, cta_ctrl and the top level import this package.
package cta_pkg;

	localparam int WORD_W     = 16;
	localparam int SAMPLE_W   = 12;
	localparam int CHAN_W     = 4;
	localparam int SUM_W      = 20;
	localparam int WIN_W      = 8;
	localparam int VREF_W     = 13;
	localparam int MV_W       = 13;
	localparam int PROD_W     = SAMPLE_W + VREF_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [SUM_W-1:0]    SUM_MAX      = '1;
	localparam logic [SAMPLE_W-1:0] CODE_MAX     = 12'd4095;
	localparam logic [WIN_W-1:0]    WINDOW_RESET = 8'd16;
	localparam logic [VREF_W-1:0]   VREF_RESET   = 13'd3300;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AVG_WINDOW = 1'b0,
		CFG_VREF_MV    = 1'b1
	} cta_cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch the input beat
		logic update;     // frame step and accumulator write
		logic div_start;  // launch the average division
		logic mul;        // saturate quotient, multiply by vref
		logic scale;      // divide product by full scale
		logic out_load;   // load the output register
	} cta_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic div_done;
	} cta_status_t;

endpackage

[rtl/cta_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one converter word with its frame flag per beat.
// Standalone interface, no package dependency.
interface cta_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] adc_word;
	logic        frame_start;

	modport source (output valid, output adc_word, output frame_start, input ready);
	modport sink (input valid, input adc_word, input frame_start, output ready);
endinterface

[rtl/cta_out_if.sv]
`timescale 1ns / 1ps
// Result channel: channel id, average code, millivolts and bad-channel flag.
// Standalone interface, no package dependency.
interface cta_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  channel;
	logic [11:0] average_code;
	logic [12:0] voltage_mv;
	logic        bad_channel;

	modport source (output valid, output channel, output average_code,
		output voltage_mv, output bad_channel, input ready);
	modport sink (input valid, input channel, input average_code,
		input voltage_mv, input bad_channel, output ready);
endinterface

[rtl/cta_cfg_if.sv]
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Standalone interface, no package dependency.
interface cta_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [12:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/cta_divider.sv]
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle.
// No package dependency.
module cta_divider #(
	parameter int DIVIDEND_W = 20,
	parameter int DIVISOR_W  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0] shifted;
	logic               ge;
	logic [DIVISOR_W:0] diff;

	// remainder stays below the divisor, so it fits DIVISOR_W bits
	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q) else $error("divider done without a run");

endmodule

[rtl/cta_datapath.sv]
`timescale 1ns / 1ps
// Datapath: config registers, frame counter, per-channel sums, average
// division, millivolt scaling and the output register. Uses cta_pkg, cta_divider.
module cta_datapath #(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [cta_pkg::WORD_W-1:0]            adc_word,
	input  logic                                  frame_start,
	input  logic                                  cfg_we,
	input  logic [cta_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cta_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  cta_pkg::cta_cmd_t                     cmd,
	output cta_pkg::cta_status_t                  status,
	output logic [cta_pkg::CHAN_W-1:0]            channel,
	output logic [cta_pkg::SAMPLE_W-1:0]          average_code,
	output logic [cta_pkg::MV_W-1:0]              voltage_mv,
	output logic                                  bad_channel
);
	import cta_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [WIN_W-1:0]    window_q;
	logic [VREF_W-1:0]   vref_q;
	logic [WIN_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    sums_q [NUM_CHANNELS];
	logic [WORD_W-1:0]   word_q;
	logic                start_q;
	logic [SUM_W-1:0]    sum_s1;
	logic [WIN_W-1:0]    divisor_s1;
	logic [SAMPLE_W-1:0] avg_q;
	logic [PROD_W-1:0]   prod_q;
	logic [MV_W-1:0]     mv_q;

	logic [CHAN_W-1:0]   ch;
	logic [SAMPLE_W-1:0] sample;
	logic [IDX_W-1:0]    idx;
	logic                bad;
	logic [WIN_W-1:0]    cnt_inc;
	logic                wrap;
	logic [WIN_W-1:0]    cnt_new;
	logic [SUM_W-1:0]    old_sum;
	logic [SUM_W:0]      sum_ext;
	logic [SUM_W-1:0]    sum_sat;
	logic                div_done;
	logic [SUM_W-1:0]    quotient;
	logic [SAMPLE_W-1:0] avg_sat;
	logic [MV_W-1:0]     t_hi;
	logic [MV_W:0]       s_rem;
	logic [MV_W-1:0]     mv_new;

	assign ch     = word_q[CHAN_W-1:0];
	assign sample = word_q[WORD_W-1:CHAN_W];
	assign idx    = ch[IDX_W-1:0];
	assign bad    = {1'b0, ch} >= (CHAN_W+1)'(NUM_CHANNELS);

	// frame step first, then the accumulate sees the cleared sums
	always_comb begin
		cnt_inc = cnt_q + 1'b1;
		wrap    = start_q && (cnt_inc == window_q);
		if (!start_q)
			cnt_new = cnt_q;
		else if (wrap)
			cnt_new = WIN_W'(1);
		else
			cnt_new = cnt_inc;
		old_sum = wrap ? '0 : sums_q[idx];
		sum_ext = {1'b0, old_sum} + (SUM_W+1)'(sample);
		sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			vref_q   <= VREF_RESET;
			cnt_q    <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++)
				sums_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_AVG_WINDOW: window_q <= cfg_data[WIN_W-1:0];
					CFG_VREF_MV:    vref_q   <= cfg_data[VREF_W-1:0];
					default: ;
				endcase
			end
			if (cmd.update) begin
				cnt_q <= cnt_new;
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (!bad && idx == IDX_W'(i))
						sums_q[i] <= sum_sat;
					else if (wrap)
						sums_q[i] <= '0;
				end
			end
		end
	end

	cta_divider #(
		.DIVIDEND_W(SUM_W),
		.DIVISOR_W (WIN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(sum_s1),
		.divisor (divisor_s1),
		.done    (div_done),
		.quotient(quotient)
	);

	assign avg_sat = (quotient > SUM_W'(CODE_MAX)) ? CODE_MAX : quotient[SAMPLE_W-1:0];

	// p / 4095 with p = 4096*t + u: q = t + (t + u) / 4095, and t + u < 3*4095
	assign t_hi   = prod_q[PROD_W-1:SAMPLE_W];
	assign s_rem  = {1'b0, t_hi} + (MV_W+1)'(prod_q[SAMPLE_W-1:0]);
	assign mv_new = t_hi + MV_W'(s_rem >= (MV_W+1)'(CODE_MAX))
		+ MV_W'(s_rem >= (MV_W+1)'({CODE_MAX, 1'b0}));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q  <= adc_word;
			start_q <= frame_start;
		end
		if (cmd.update) begin
			sum_s1     <= sum_sat;
			divisor_s1 <= (cnt_new == '0) ? WIN_W'(1) : cnt_new;
		end
		if (cmd.mul) begin
			avg_q  <= avg_sat;
			prod_q <= PROD_W'(avg_sat) * PROD_W'(vref_q);
		end
		if (cmd.scale)
			mv_q <= mv_new;
		if (cmd.out_load) begin
			channel      <= ch;
			bad_channel  <= bad;
			average_code <= bad ? '0 : avg_q;
			voltage_mv   <= bad ? '0 : mv_q;
		end
	end

	assign status.bad      = bad;
	assign status.div_done = div_done;

	a_wrap_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && wrap |=> cnt_q == WIN_W'(1)) else $error("frame count not restarted");
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> divisor_s1 != '0) else $error("division by zero launched");

endmodule

[rtl/cta_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences one beat through update, divide, multiply, scale and output;
// a bad channel id goes straight from update to output. Uses cta_pkg.
module cta_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cta_pkg::cta_cmd_t    cmd,
	input  cta_pkg::cta_status_t status
);
	import cta_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_DIV_GO,
		S_WAIT,
		S_MUL,
		S_SCALE,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.capture   = in_valid && in_ready;
		cmd.update    = (state_q == S_UPDATE);
		cmd.div_start = (state_q == S_DIV_GO);
		cmd.mul       = (state_q == S_MUL);
		cmd.scale     = (state_q == S_SCALE);
		cmd.out_load  = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					// a bad id skips the arithmetic, result fields are zeroed
					state_q <= status.bad ? S_DONE : S_DIV_GO;
				end
				S_DIV_GO: state_q <= S_WAIT;
				S_WAIT: begin
					if (status.div_done)
						state_q <= S_MUL;
				end
				S_MUL:   state_q <= S_SCALE;
				S_SCALE: state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> state_q == S_WAIT) else $error("divider finished out of sequence");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ready)) else $error("held result overwritten");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready) else $error("second beat taken while busy");

endmodule

[rtl/channel_tagged_adc_averager_top.sv]
`timescale 1ns / 1ps
// Channel   | Dir | Payload                                       | Beat when
// adc_in    | in  | adc_word[15:0], frame_start                   | valid & ready
// avg_out   | out | channel[3:0], average_code[11:0],             | valid & ready
//           |     | voltage_mv[12:0], bad_channel                 |
// cfg       | in  | index[0] (0 average_window, 1 vref_mv), data  | valid & ready, always ready
//
// After the input beat the result passes through accumulate, divider launch,
// restoring division of the 20-bit sum, multiply by vref, scale by 1/4095 and
// output load, which waits for a free output register. The next beat is taken only
// once the controller is idle again. A bad channel id skips the arithmetic.
// The result sits in an output register, so the next beat is taken while it waits.
// Reset loads config defaults, clears frame count and all channel sums at once; no sweep.
// Top level; uses cta_pkg, the channel interfaces, cta_ctrl and cta_datapath.
module channel_tagged_adc_averager_top #(
	parameter int NUM_CHANNELS = 8
) (
	input logic       clk,
	input logic       arst_n,
	cta_in_if.sink    adc_in,
	cta_out_if.source avg_out,
	cta_cfg_if.sink   cfg
);
	import cta_pkg::*;

	cta_cmd_t    cmd;
	cta_status_t status;

	assign cfg.ready = 1'b1;

	cta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (adc_in.valid),
		.in_ready (adc_in.ready),
		.out_valid(avg_out.valid),
		.out_ready(avg_out.ready),
		.cmd      (cmd),
		.status   (status)
	);

	cta_datapath #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.adc_word    (adc_in.adc_word),
		.frame_start (adc_in.frame_start),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.cmd         (cmd),
		.status      (status),
		.channel     (avg_out.channel),
		.average_code(avg_out.average_code),
		.voltage_mv  (avg_out.voltage_mv),
		.bad_channel (avg_out.bad_channel)
	);

endmodule
